// ----- hdl/crcr_pkg.sv -----
// Package for the circle versus rectangle collision block.
// Holds the input and output word types, the rectangle entry type, op codes
// and the saturation helper. No dependencies.
package crcr_pkg;

	localparam int MAX_RECTS_DFLT = 256;
	localparam int COORD_W = 16;
	localparam int RECT_F_W = 15;
	localparam int WIDE_W = 18;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_LOAD    = 2'd1,
		OP_RESOLVE = 2'd2,
		OP_UNUSED  = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]                 op;
		logic [RECT_F_W-1:0]        rect_x;
		logic [RECT_F_W-1:0]        rect_y;
		logic [RECT_F_W-1:0]        rect_w;
		logic [RECT_F_W-1:0]        rect_h;
		logic signed [COORD_W-1:0]  pos_x;
		logic signed [COORD_W-1:0]  pos_y;
		logic signed [COORD_W-1:0]  prev_x;
		logic signed [COORD_W-1:0]  prev_y;
		logic [7:0]                 radius;
	} in_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0]  new_x;
		logic signed [COORD_W-1:0]  new_y;
		logic                       hit;
	} out_word_t;

	typedef struct packed {
		logic [RECT_F_W-1:0] x;
		logic [RECT_F_W-1:0] y;
		logic [RECT_F_W-1:0] w;
		logic [RECT_F_W-1:0] h;
	} rect_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic [7:0]                rad;
	} circ_t;

	typedef struct packed {
		logic                      hit;
		logic                      push_x;
		logic signed [COORD_W-1:0] push_val;
	} step_res_t;

	function automatic logic signed [COORD_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] lo;
		logic signed [WIDE_W-1:0] hi;
		lo = -18'sd32768;
		hi = 18'sd32767;
		if (v < lo) begin
			return lo[COORD_W-1:0];
		end else if (v > hi) begin
			return hi[COORD_W-1:0];
		end else begin
			return v[COORD_W-1:0];
		end
	endfunction

endpackage

// ----- hdl/crcr_step.sv -----
// One rectangle test of the collision walk, split into a registered part and a combinational part.
// The first part registers the clamped distances, the squared radius and the push choice;
// the second squares and compares from those registers. Depends on crcr_pkg.
module crcr_step import crcr_pkg::*; (
	input  logic      clk,
	input  logic      load,
	input  rect_t     rect,
	input  circ_t     circ,
	output step_res_t res
);

	logic signed [WIDE_W-1:0] cx, cy, px, py;
	logic signed [WIDE_W-1:0] rx, ry, rr, rb, rad18, half18;
	logic signed [WIDE_W-1:0] ax_w, ay_w;
	logic                     band, go_left, go_right, go_top;
	logic signed [COORD_W-1:0] push_val;

	logic [8:0]               ax_s1, ay_s1;
	logic [15:0]              rad2_s1;
	logic                     push_x_s1;
	logic signed [COORD_W-1:0] push_val_s1;

	logic [17:0]              sq_sum;

	always_comb begin
		cx = {{2{circ.cx[COORD_W-1]}}, circ.cx};
		cy = {{2{circ.cy[COORD_W-1]}}, circ.cy};
		px = {{2{circ.px[COORD_W-1]}}, circ.px};
		py = {{2{circ.py[COORD_W-1]}}, circ.py};
		rx = {3'b000, rect.x};
		ry = {3'b000, rect.y};
		rr = rx + {3'b000, rect.w};
		rb = ry + {3'b000, rect.h};
		rad18 = {10'b0, circ.rad};
		half18 = {11'b0, circ.rad[7:1]};

		if (cx < rx) begin
			ax_w = rx - cx;
		end else if (cx > rr) begin
			ax_w = cx - rr;
		end else begin
			ax_w = '0;
		end
		if (cy < ry) begin
			ay_w = ry - cy;
		end else if (cy > rb) begin
			ay_w = cy - rb;
		end else begin
			ay_w = '0;
		end

		band = (py >= ry - rad18) && (py <= rb + rad18);
		go_left = (px <= rx - half18) && band;
		go_right = (px >= rr + rad18) && band;
		go_top = (py <= ry - rad18) && (px >= rx - rad18) && (px <= rr + rad18);

		if (go_left) begin
			push_val = sat16(rx - rad18);
		end else if (go_right) begin
			push_val = sat16(rr + rad18);
		end else if (go_top) begin
			push_val = sat16(ry - rad18);
		end else begin
			push_val = sat16(rb + rad18);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ax_s1 <= (ax_w >= 18'sd256) ? 9'd256 : ax_w[8:0];
			ay_s1 <= (ay_w >= 18'sd256) ? 9'd256 : ay_w[8:0];
			rad2_s1 <= 16'({8'b0, circ.rad} * {8'b0, circ.rad});
			push_x_s1 <= go_left || go_right;
			push_val_s1 <= push_val;
		end
	end

	always_comb begin
		sq_sum = 18'({9'b0, ax_s1} * {9'b0, ax_s1}) + 18'({9'b0, ay_s1} * {9'b0, ay_s1});
		res.hit = sq_sum < {2'b00, rad2_s1};
		res.push_x = push_x_s1;
		res.push_val = push_val_s1;
	end

endmodule

// ----- hdl/circle_rect_collision_resolve.sv -----
// Top level of the circle versus rectangle collision block: rectangle memory,
// walk sequencer and output register. Depends on crcr_pkg and crcr_step.
//
// Usage: words enter on in_valid/in_stall/in_word and results leave on
// out_valid/out_stall/out_word. A clear word empties the rectangle table and
// a load word appends one rectangle; neither gives a result, and loads past
// MAX_RECTS are dropped. A resolve word walks the stored rectangles in load
// order, one at a time, because the pushed centre of one rectangle is the
// input of the next. Each test is a memory read followed by the registered
// distance stage (ST_EVAL) and the compare and push (ST_APPLY). A resolve
// steps through ST_RD, then ST_EVAL and ST_APPLY for each stored rectangle,
// then ST_FIN, where the result goes into the output register; with an empty table it goes straight to ST_FIN.
// The block takes one word at a time: in_stall is high while a resolve is
// walking or waiting to hand its result over. The result waits in an output
// register, so clear and load words are taken while out_stall holds it.
// A finished walk waits until the output register is free.
// Reset empties the table and drops any pending result; stored rectangle
// contents are not cleared.
module circle_rect_collision_resolve import crcr_pkg::*; #(
	parameter int MAX_RECTS = MAX_RECTS_DFLT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_word,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	localparam int CNT_W = $clog2(MAX_RECTS + 1);
	localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_RD    = 5'b00010,
		ST_EVAL  = 5'b00100,
		ST_APPLY = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] idx_nxt;
	logic             out_valid_q;
	out_word_t        out_q;
	circ_t            circ_q;
	logic             hit_q;

	rect_t            rect_mem [MAX_RECTS];
	rect_t            rd_q;
	logic [IDX_W-1:0] rd_idx;
	logic             wr_en;
	logic             in_acc;
	logic             out_acc;
	logic             out_free;
	logic             last;
	step_res_t        step_res;

	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_word = out_q;

	assign idx_nxt = CNT_W'(idx_q + 1'b1);
	assign last = (idx_nxt == cnt_q);
	assign rd_idx = (state_q == ST_APPLY) ? idx_nxt[IDX_W-1:0] : idx_q[IDX_W-1:0];
	assign wr_en = in_acc && (in_word.op == OP_LOAD) && (cnt_q < CNT_W'(MAX_RECTS));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rect_mem[cnt_q[IDX_W-1:0]] <= '{x: in_word.rect_x, y: in_word.rect_y,
				w: in_word.rect_w, h: in_word.rect_h};
		end
		rd_q <= rect_mem[rd_idx];
	end

	crcr_step u_step (
		.clk  (clk),
		.load (state_q == ST_EVAL),
		.rect (rd_q),
		.circ (circ_q),
		.res  (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_acc) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (in_word.op)
							OP_CLEAR: cnt_q <= '0;
							OP_LOAD: begin
								if (wr_en) begin
									cnt_q <= CNT_W'(cnt_q + 1'b1);
								end
							end
							OP_RESOLVE: begin
								idx_q <= '0;
								state_q <= (cnt_q == '0) ? ST_FIN : ST_RD;
							end
							default: ;
						endcase
					end
				end
				ST_RD: state_q <= ST_EVAL;
				ST_EVAL: state_q <= ST_APPLY;
				ST_APPLY: begin
					if (last) begin
						state_q <= ST_FIN;
					end else begin
						idx_q <= idx_nxt;
						state_q <= ST_EVAL;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (in_word.op == OP_RESOLVE)) begin
			circ_q <= '{cx: in_word.pos_x, cy: in_word.pos_y, px: in_word.prev_x,
				py: in_word.prev_y, rad: in_word.radius};
			hit_q <= 1'b0;
		end else if ((state_q == ST_APPLY) && step_res.hit) begin
			hit_q <= 1'b1;
			if (step_res.push_x) begin
				circ_q.cx <= step_res.push_val;
			end else begin
				circ_q.cy <= step_res.push_val;
			end
		end
		if ((state_q == ST_FIN) && out_free) begin
			out_q <= '{new_x: circ_q.cx, new_y: circ_q.cy, hit: hit_q};
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RECTS))
		else $error("Rectangle count exceeds the table size.");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY) |-> (idx_q < cnt_q))
		else $error("Walk index passed the rectangle count.");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("Result word appeared without a finished walk.");

	a_empty_resolve: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (in_word.op == OP_RESOLVE) && (cnt_q == '0)) |=> (state_q == ST_FIN))
		else $error("Resolve on an empty table did not finish at once.");

endmodule
